### rtl/dsvr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsvr_pkg
// Shared types and constants for the debounced sensor vote relay.
// ----------------------------------------------------------------------------
package dsvr_pkg;

   localparam int CHAN_COUNT = 5;
   localparam int TIME_W     = 32;
   localparam int PULSE_W    = 31;
   localparam int THR_W      = 3;
   localparam int CNT_W      = $clog2(CHAN_COUNT + 1);
   localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;

   localparam logic [TIME_W-1:0]     RST_CHAN_DEB  = 32'd500;
   localparam logic [TIME_W-1:0]     RST_AGG_DEB   = 32'd500;
   localparam logic                  RST_OR_MODE   = 1'b0;
   localparam logic [THR_W-1:0]      RST_OFF_THR   = 3'd1;
   localparam logic [CHAN_COUNT-1:0] RST_ENABLE    = '1;
   localparam logic [PULSE_W-1:0]    RST_PULSE     = 31'd2000;

   typedef enum logic [2:0] {
      REG_CHAN_DEB  = 3'd0,
      REG_AGG_DEB   = 3'd1,
      REG_OR_MODE   = 3'd2,
      REG_OFF_THR   = 3'd3,
      REG_ENABLE    = 3'd4,
      REG_PULSE     = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [TIME_W-1:0]     now_ms;
      logic [CHAN_COUNT-1:0] sensor_raw;
      logic [CHAN_COUNT-1:0] test_start;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_COUNT-1:0] relay_out;
      logic [CHAN_COUNT-1:0] position_state;
      logic [CHAN_COUNT-1:0] position_changed;
      logic                  aggregate_on;
      logic                  aggregate_changed;
   } rsp_word_type;

   typedef struct packed {
      logic [TIME_W-1:0]     channel_debounce_ms;
      logic [TIME_W-1:0]     aggregate_debounce_ms;
      logic                  or_mode;
      logic [THR_W-1:0]      off_threshold;
      logic [CHAN_COUNT-1:0] enable_mask;
      logic [PULSE_W-1:0]    test_pulse_ms;
   } cfg_type;

   typedef struct packed {
      logic relay;
      logic position;
      logic changed;
   } lane_res_type;

endpackage
`default_nettype wire

### rtl/debounced_sensor_vote_relay_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_sensor_vote_relay_core
// Per-channel debounce and test pulse lanes with a debounced all-on/threshold-off or OR vote.
// ----------------------------------------------------------------------------
// Each word on req carries a timestamp, raw detect bits and test requests and
// yields exactly one word on rsp. All channel lanes and the aggregate vote work
// on a word in the cycle it is accepted; the result sits in a single output
// register, so one word per cycle is taken while rsp_ready is high; rsp_valid
// rises in the cycle after acceptance. Registers are written over the APB port
// at byte address 4*i and must only be changed while no word is in flight.
module debounced_sensor_vote_relay_core
   import dsvr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire req_word_type      req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      rsp_word_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output      logic [DATA_W-1:0] prdata,
   output      logic              pready
);

   cfg_type      cfg_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff;
   rsp_word_type merged;
   lane_res_type lane_res [CHAN_COUNT];
   logic         step;
   logic         wr_en;
   reg_idx_type  reg_idx;

   // config registers
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_idx_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_debounce_ms   <= RST_CHAN_DEB;
         cfg_ff.aggregate_debounce_ms <= RST_AGG_DEB;
         cfg_ff.or_mode               <= RST_OR_MODE;
         cfg_ff.off_threshold         <= RST_OFF_THR;
         cfg_ff.enable_mask           <= RST_ENABLE;
         cfg_ff.test_pulse_ms         <= RST_PULSE;
      end else if (wr_en) begin
         case (reg_idx)
            REG_CHAN_DEB: cfg_ff.channel_debounce_ms   <= pwdata;
            REG_AGG_DEB:  cfg_ff.aggregate_debounce_ms <= pwdata;
            REG_OR_MODE:  cfg_ff.or_mode               <= pwdata[0];
            REG_OFF_THR:  cfg_ff.off_threshold         <= pwdata[THR_W-1:0];
            REG_ENABLE:   cfg_ff.enable_mask           <= pwdata[CHAN_COUNT-1:0];
            REG_PULSE:    cfg_ff.test_pulse_ms         <= pwdata[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CHAN_DEB: prdata = cfg_ff.channel_debounce_ms;
         REG_AGG_DEB:  prdata = cfg_ff.aggregate_debounce_ms;
         REG_OR_MODE:  prdata = DATA_W'(cfg_ff.or_mode);
         REG_OFF_THR:  prdata = DATA_W'(cfg_ff.off_threshold);
         REG_ENABLE:   prdata = DATA_W'(cfg_ff.enable_mask);
         REG_PULSE:    prdata = DATA_W'(cfg_ff.test_pulse_ms);
         default:      prdata = '0;
      endcase
   end

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   for (genvar g = 0; g < CHAN_COUNT; g++) begin : g_lane
      dsvr_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .step       (step),
         .now_ms     (req_data.now_ms),
         .raw_bit    (req_data.sensor_raw[g]),
         .test_bit   (req_data.test_start[g]),
         .enable_bit (cfg_ff.enable_mask[g]),
         .cfg        (cfg_ff),
         .res        (lane_res[g])
      );
   end

   dsvr_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .now_ms     (req_data.now_ms),
      .sensor_raw (req_data.sensor_raw),
      .cfg        (cfg_ff),
      .lane_res   (lane_res),
      .word       (merged)
   );

   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_step_gives_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word did not produce a result");

   a_pos_in_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.position_state & ~rsp_data.relay_out) == '0)
      else $error("position bit set without relay drive");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result is stalled");

endmodule
`default_nettype wire

### rtl/dsvr_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsvr_lane
// One channel: raw bit debounce, test pulse timer, position change flag.
// ----------------------------------------------------------------------------
module dsvr_lane
   import dsvr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [TIME_W-1:0]   now_ms,
   input  wire logic                raw_bit,
   input  wire logic                test_bit,
   input  wire logic                enable_bit,
   input  wire cfg_type             cfg,
   output lane_res_type             res
);

   logic              last_raw_ff, last_raw_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              deb_ff, deb_in;
   logic              last_rep_ff, last_rep_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic              pending_ff, pending_in;

   logic              raw_chg;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] left;
   logic              active;
   logic              eff;

   always_comb begin
      raw_chg        = raw_bit != last_raw_ff;
      last_raw_in    = raw_bit;
      change_time_in = raw_chg ? now_ms : change_time_ff;
      elapsed        = raw_chg ? '0 : (now_ms - change_time_ff);
      deb_in         = (elapsed >= cfg.channel_debounce_ms) ? raw_bit : deb_ff;

      // new request: remaining time is the pulse length itself
      deadline_in = test_bit ? (now_ms + {1'b0, cfg.test_pulse_ms}) : deadline_ff;
      left        = test_bit ? {1'b0, cfg.test_pulse_ms} : (deadline_ff - now_ms);
      active      = (test_bit || pending_ff) && (left != '0) && !left[TIME_W-1];
      pending_in  = active;

      eff         = deb_in & enable_bit;
      last_rep_in = eff;

      res.relay    = eff | active;
      res.position = eff;
      res.changed  = eff != last_rep_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b0;
         change_time_ff <= '0;
         deb_ff         <= 1'b0;
         last_rep_ff    <= 1'b0;
         deadline_ff    <= '0;
         pending_ff     <= 1'b0;
      end else if (step) begin
         last_raw_ff    <= last_raw_in;
         change_time_ff <= change_time_in;
         deb_ff         <= deb_in;
         last_rep_ff    <= last_rep_in;
         deadline_ff    <= deadline_in;
         pending_ff     <= pending_in;
      end
   end

endmodule
`default_nettype wire

### rtl/dsvr_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsvr_merge
// Collects lane results and runs the debounced aggregate vote.
// ----------------------------------------------------------------------------
module dsvr_merge
   import dsvr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [TIME_W-1:0]     now_ms,
   input  wire logic [CHAN_COUNT-1:0] sensor_raw,
   input  wire cfg_type               cfg,
   input  wire lane_res_type          lane_res [CHAN_COUNT],
   output rsp_word_type               word
);

   logic              pend_ff, pend_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] dec_time_ff, dec_time_in;

   logic [CMP_W-1:0]  enabled;
   logic [CMP_W-1:0]  present;
   logic [CMP_W-1:0]  removed;
   logic [CMP_W-1:0]  thr;
   logic              decision;
   logic              dec_chg;
   logic [TIME_W-1:0] elapsed;
   logic              agg_chg;

   always_comb begin
      enabled = '0;
      present = '0;
      for (int i = 0; i < CHAN_COUNT; i++) begin
         enabled = enabled + CMP_W'(cfg.enable_mask[i]);
         present = present + CMP_W'(cfg.enable_mask[i] & sensor_raw[i]);
      end
      removed = enabled - present;
      thr     = CMP_W'(cfg.off_threshold);
      if (thr > enabled) begin
         thr = enabled;
      end

      if (enabled == '0) begin
         decision = 1'b0;
      end else if (cfg.or_mode) begin
         decision = present != '0;
      end else if (!stable_ff) begin
         decision = removed == '0;
      end else begin
         decision = removed < thr;
      end

      dec_chg     = decision != pend_ff;
      pend_in     = decision;
      dec_time_in = dec_chg ? now_ms : dec_time_ff;
      elapsed     = dec_chg ? '0 : (now_ms - dec_time_ff);
      agg_chg     = (elapsed >= cfg.aggregate_debounce_ms) && (stable_ff != pend_in);
      stable_in   = agg_chg ? pend_in : stable_ff;

      for (int i = 0; i < CHAN_COUNT; i++) begin
         word.relay_out[i]        = lane_res[i].relay;
         word.position_state[i]   = lane_res[i].position;
         word.position_changed[i] = lane_res[i].changed;
      end
      word.aggregate_on      = stable_in;
      word.aggregate_changed = agg_chg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         stable_ff   <= 1'b0;
         dec_time_ff <= '0;
      end else if (step) begin
         pend_ff     <= pend_in;
         stable_ff   <= stable_in;
         dec_time_ff <= dec_time_in;
      end
   end

endmodule
`default_nettype wire
